// ----- rtl/gbn_pkg.sv -----
`default_nettype none

package gbn_pkg;

	// Sequence space of the link and the widths that follow from it.
	localparam int SEQ_SPACE = 32;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int OUTST_W   = SEQ_W + 1;

	// Fixed field widths.
	localparam int CNT_W     = 16;
	localparam int WIN_W     = 5;
	localparam int TMO_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd2;

	// Configuration reset values.
	localparam logic [CNT_W-1:0] TOTAL_PACKETS_RST = 16'd1;
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 5'd4;
	localparam logic [TMO_W-1:0] TIMEOUT_LIMIT_RST = 8'd10;

	typedef struct packed {
		logic [CNT_W-1:0] total_packets;
		logic [WIN_W-1:0] window_size;
		logic [TMO_W-1:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic             ack_present;
		logic [SEQ_W-1:0] ack_seq;
	} round_t;

	typedef struct packed {
		logic             send_valid;
		logic [SEQ_W-1:0] send_seq;
		logic [CNT_W-1:0] packet_index;
		logic             last_packet;
		logic             ack_accepted;
		logic             went_back;
		logic [CNT_W-1:0] acked_total;
		logic             done_res;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/gbn_cfg.sv -----
`default_nettype none

module gbn_cfg import gbn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Register file; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_packets <= TOTAL_PACKETS_RST;
			cfg_q.window_size   <= WINDOW_SIZE_RST;
			cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL_PACKETS: cfg_q.total_packets <= cfg_data[CNT_W-1:0];
				REG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data[WIN_W-1:0];
				REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/gbn_window.sv -----
`default_nettype none

module gbn_window import gbn_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   step,
	input  wire cfg_t   cfg,
	input  wire round_t rnd,
	output res_t        res
);

	logic [SEQ_SPACE-1:0] slot_free_q;
	logic [CNT_W-1:0]     sent_q;
	logic [CNT_W-1:0]     acked_q;
	logic [TMO_W-1:0]     silent_q;

	logic [CNT_W-1:0]     outst_full;
	logic [OUTST_W-1:0]   outst;
	logic [OUTST_W-1:0]   outst_sent;
	logic [SEQ_W-1:0]     slot;
	logic [SEQ_W-1:0]     base;
	logic [SEQ_W-1:0]     ack_dist;
	logic                 can_send;
	logic                 accept;
	logic                 fire;
	logic [CNT_W-1:0]     sent_inc;
	logic [CNT_W-1:0]     sent_n;
	logic [CNT_W-1:0]     acked_n;
	logic [TMO_W-1:0]     silent_n;
	logic [SEQ_SPACE-1:0] free_mask;
	logic [SEQ_SPACE-1:0] slot_free_n;

	// Send decision: packets remain, window has room, slot is free.
	always_comb begin
		outst_full = sent_q - acked_q;
		outst      = outst_full[OUTST_W-1:0];
		slot       = sent_q[SEQ_W-1:0];
		can_send   = (sent_q < cfg.total_packets) &&
		             (outst < {1'b0, cfg.window_size}) &&
		             slot_free_q[slot];
		sent_inc   = sent_q + {{(CNT_W-1){1'b0}}, can_send};
		outst_sent = outst + {{(OUTST_W-1){1'b0}}, can_send};
	end

	// Ack or silent round handling.
	always_comb begin
		base     = acked_q[SEQ_W-1:0];
		ack_dist = rnd.ack_seq - base;
		accept   = rnd.ack_present && ({1'b0, ack_dist} < outst_sent);
		fire     = !rnd.ack_present && (silent_q >= cfg.timeout_limit);
		acked_n  = accept ? acked_q + {{(CNT_W-SEQ_W){1'b0}}, ack_dist} + 1'b1 : acked_q;
		sent_n   = fire ? acked_q : sent_inc;
		if (rnd.ack_present || fire) begin
			silent_n = '0;
		end else begin
			silent_n = silent_q + 1'b1;
		end
	end

	// Slot bitmap: clear the sent slot, then set the freed range from the base.
	always_comb begin
		logic [SEQ_W-1:0] off;
		for (int i = 0; i < SEQ_SPACE; i++) begin
			off = SEQ_W'(i) - base;
			free_mask[i] = (accept && (off <= ack_dist)) ||
			               (fire && ({1'b0, off} < outst_sent));
		end
		slot_free_n = slot_free_q;
		if (can_send) begin
			slot_free_n[slot] = 1'b0;
		end
		slot_free_n = slot_free_n | free_mask;
	end

	// Round state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_free_q <= '1;
			sent_q      <= '0;
			acked_q     <= '0;
			silent_q    <= '0;
		end else if (step) begin
			slot_free_q <= slot_free_n;
			sent_q      <= sent_n;
			acked_q     <= acked_n;
			silent_q    <= silent_n;
		end
	end

	// Result of the round.
	always_comb begin
		res.send_valid   = can_send;
		res.send_seq     = can_send ? slot : '0;
		res.packet_index = can_send ? sent_q : '0;
		res.last_packet  = can_send && (sent_inc == cfg.total_packets);
		res.ack_accepted = accept;
		res.went_back    = fire;
		res.acked_total  = acked_n;
		res.done_res     = acked_n >= cfg.total_packets;
	end

`ifndef SYNTH
	a_acked_not_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		acked_q <= sent_q)
		else $error("acked count ran ahead of sent count");

	a_next_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		slot_free_q[sent_q[SEQ_W-1:0]])
		else $error("slot of the next packet is still outstanding");

	a_goback_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		step && fire |=> sent_q == acked_q && silent_q == '0)
		else $error("go-back did not rewind the window");
`endif

endmodule

`default_nettype wire

// ----- rtl/go_back_n_sender_window.sv -----
// Go-Back-N sender window: one input item is one round of the send loop.
// Input channel (in_valid / in_stall) carries ack_present and ack_seq; a
// silent round is an item with ack_present low. Each round yields exactly
// one result item on the output channel (out_valid / out_stall): whether a
// packet is sent and its sequence and index, whether the ack advanced the
// window, whether a timeout rewound it, the acked count and done.
// Configuration registers (total_packets, window_size, timeout_limit) are
// written through cfg_valid / cfg_index / cfg_data; cfg_ready is always high.
// An accepted item is registered in the input register, processed by a
// single pass of window logic and written into the result register.
// Throughput is one item per clock while out_stall is low, as the slot
// bitmap and the sent / acked counters are updated once per round.
// Reset clears all slots to free, the counters to zero and the registers to
// their defaults (1, 4, 10). When the receiver stalls, the result holds,
// one more item is taken into the input register, and then in_stall rises
// until the result is taken.
`default_nettype none

module go_back_n_sender_window import gbn_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 ack_present,
	input  wire logic [SEQ_W-1:0]     ack_seq,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      send_valid,
	output logic [SEQ_W-1:0]          send_seq,
	output logic [CNT_W-1:0]          packet_index,
	output logic                      last_packet,
	output logic                      ack_accepted,
	output logic                      went_back,
	output logic [CNT_W-1:0]          acked_total,
	output logic                      done_res,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t   cfg;
	round_t rnd_s1;
	logic   valid_s1;
	res_t   res;
	res_t   res_q;
	logic   out_valid_q;
	logic   advance;
	logic   in_take;

	assign cfg_ready = 1'b1;

	gbn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the input register drains whenever the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rnd_s1.ack_present <= ack_present;
			rnd_s1.ack_seq     <= ack_seq;
		end
	end

	gbn_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.rnd    (rnd_s1),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign send_valid   = res_q.send_valid;
	assign send_seq     = res_q.send_seq;
	assign packet_index = res_q.packet_index;
	assign last_packet  = res_q.last_packet;
	assign ack_accepted = res_q.ack_accepted;
	assign went_back    = res_q.went_back;
	assign acked_total  = res_q.acked_total;
	assign done_res     = res_q.done_res;

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled while the pipeline could move");

	a_result_follows_round: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed round produced no result");

	a_held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
